/* hw/rtl/hysteresis_frequency_duty_meter_defines.svh */
// Assertion macros for the hysteresis frequency and duty meter checker
`ifndef HYSTERESIS_FREQUENCY_DUTY_METER_DEFINES_SVH
`define HYSTERESIS_FREQUENCY_DUTY_METER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define HFDM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define HFDM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/hfdm_pkg.sv */
// Shared types and constants of the hysteresis frequency and duty meter
package hfdm_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int FREQ_W        = 39;
    localparam int DUTY_W        = 15;
    localparam int WINDOW_W      = 32;
    localparam int FRAC_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int FREQ_SCALE_W  = 28;
    localparam int DUTY_SCALE_W  = 15;

    localparam logic [FREQ_SCALE_W-1:0] FREQ_SCALE = 28'd256000000;
    localparam logic [DUTY_SCALE_W-1:0] DUTY_SCALE = 15'd25600;
    localparam logic [FREQ_W-1:0]       FREQ_MAX   = {FREQ_W{1'b1}};
    localparam logic [DUTY_W-1:0]       DUTY_MAX   = 15'd25600;

    localparam logic [WINDOW_W-1:0] WINDOW_RST = 32'd1000;
    localparam logic [FRAC_W-1:0]   LOW_RST    = 16'd16384;
    localparam logic [FRAC_W-1:0]   HIGH_RST   = 16'd49152;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_WINDOW = 2'd0;
    localparam t_cfg_idx CFG_LOW    = 2'd1;
    localparam t_cfg_idx CFG_HIGH   = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last_sample;
    } t_in_item;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency_q8;
        logic [DUTY_W-1:0] duty_q8;
        logic              overflow;
    } t_out_item;

    typedef struct packed {
        t_cfg_idx              index;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_req;

    typedef enum logic [3:0] {
        S_LOAD,
        S_THR_LO,
        S_THR_HI,
        S_PASS,
        S_PREP,
        S_FDIV_GO,
        S_FDIV_WAIT,
        S_DDIV_GO,
        S_DDIV_WAIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic sample_we;
        logic thr_lo;
        logic thr_hi;
        logic pass_issue;
        logic prep;
        logic div_start;
        logic div_sel_duty;
        logic take_freq;
        logic take_duty;
        logic result_load;
    } t_cmd;

    typedef struct packed {
        logic pass_done;
        logic div_done;
        logic out_busy;
    } t_status;

endpackage

/* hw/rtl/hfdm_if.sv */
// Valid/ready channel interfaces for samples, results and register writes
interface hfdm_in_if;
    logic               valid;
    logic               ready;
    hfdm_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hfdm_out_if;
    logic                valid;
    logic                ready;
    hfdm_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hfdm_cfg_if;
    logic               valid;
    logic               ready;
    hfdm_pkg::t_cfg_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/hysteresis_frequency_duty_meter.sv */
// Top level of the hysteresis frequency and duty meter
//
// Channels: i_in carries samples (sample, last_sample), o_out carries one
// result per capture (frequency_q8, duty_q8, overflow), i_cfg writes the
// registers window_time_us (0), low_fraction (1), high_fraction (2); i_cfg is
// always ready and writes take effect at the next edge.
// Between captures, samples load at one per cycle into the sample RAM while min and max are
// tracked; samples past MAX_SAMPLES are dropped and set overflow.
// After the sample marked last come the two thresholds (one shared multiplier),
// the hysteresis pass over the N stored samples (one RAM read port), the
// scaled numerators, two passes of the bit-serial divider of NUM_W =
// clog2(MAX_SAMPLES+1)+28 steps each, and then the load of the output register.
// i_in is not ready during these steps.
// Reset clears the capture state and loads the register defaults; the RAM is
// not cleared. A result waits in the output register while o_out.ready is low;
// the next capture loads meanwhile and holds at its end until the register frees.
module hysteresis_frequency_duty_meter #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hfdm_in_if.sink           i_in,
    hfdm_out_if.source        o_out,
    hfdm_cfg_if.sink          i_cfg
);

    hfdm_pkg::t_cmd    n_cmd;
    hfdm_pkg::t_status n_status;

    assign i_cfg.ready = 1'b1;

    hfdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.data.last_sample),
        .i_status   (n_status),
        .o_in_ready (i_in.ready),
        .o_cmd      (n_cmd)
    );

    hfdm_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_req   (i_cfg.data),
        .i_sample    (i_in.data.sample),
        .i_cmd       (n_cmd),
        .o_status    (n_status),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (o_out.data)
    );

endmodule

/* hw/rtl/hfdm_ram.sv */
// Generic single-write, single-read RAM with registered read data
module hfdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/hfdm_div.sv */
// Iterative restoring divider, one quotient bit per cycle
module hfdm_div #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [DEN_W:0]    r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    n_trial;
    logic              n_fit;

    assign n_trial = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign n_fit   = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(NUM_W);
        end else if (r_busy) begin
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy && r_step != '0) begin
            r_rem <= n_fit ? (n_trial - {1'b0, r_den}) : n_trial;
            r_num <= {r_num[NUM_W-2:0], n_fit};
        end
    end

    assign o_done = r_busy && (r_step == '0);
    assign o_quot = r_num;

endmodule

/* hw/rtl/hfdm_ctrl.sv */
// Capture sequencer: load, thresholds, hysteresis pass, divisions, result
module hfdm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  hfdm_pkg::t_status i_status,
    output logic              o_in_ready,
    output hfdm_pkg::t_cmd    o_cmd
);

    hfdm_pkg::t_state r_state;
    hfdm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hfdm_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            hfdm_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.sample_we = 1'b1;
                    if (i_in_last) begin
                        n_state = hfdm_pkg::S_THR_LO;
                    end
                end
            end
            hfdm_pkg::S_THR_LO: begin
                o_cmd.thr_lo = 1'b1;
                n_state      = hfdm_pkg::S_THR_HI;
            end
            hfdm_pkg::S_THR_HI: begin
                o_cmd.thr_hi = 1'b1;
                n_state      = hfdm_pkg::S_PASS;
            end
            hfdm_pkg::S_PASS: begin
                if (i_status.pass_done) begin
                    n_state = hfdm_pkg::S_PREP;
                end else begin
                    o_cmd.pass_issue = 1'b1;
                end
            end
            hfdm_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = hfdm_pkg::S_FDIV_GO;
            end
            hfdm_pkg::S_FDIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = hfdm_pkg::S_FDIV_WAIT;
            end
            hfdm_pkg::S_FDIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.take_freq = 1'b1;
                    n_state         = hfdm_pkg::S_DDIV_GO;
                end
            end
            hfdm_pkg::S_DDIV_GO: begin
                o_cmd.div_start    = 1'b1;
                o_cmd.div_sel_duty = 1'b1;
                n_state            = hfdm_pkg::S_DDIV_WAIT;
            end
            hfdm_pkg::S_DDIV_WAIT: begin
                o_cmd.div_sel_duty = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.take_duty = 1'b1;
                    n_state         = hfdm_pkg::S_RESULT;
                end
            end
            hfdm_pkg::S_RESULT: begin
                if (!i_status.out_busy) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = hfdm_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = hfdm_pkg::S_LOAD;
            end
        endcase
    end

endmodule

/* hw/rtl/hfdm_dp.sv */
// Datapath: sample store, min/max, thresholds, comparator, divider, output register
module hfdm_dp #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  hfdm_pkg::t_cfg_req                   i_cfg_req,
    input  logic [hfdm_pkg::SAMPLE_W-1:0]        i_sample,
    input  hfdm_pkg::t_cmd                       i_cmd,
    output hfdm_pkg::t_status                    o_status,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output hfdm_pkg::t_out_item                  o_out_item
);

    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int PROD_W = SAMPLE_BITS + hfdm_pkg::FRAC_W;
    localparam int NUM_W  = CNT_W + hfdm_pkg::FREQ_SCALE_W;
    localparam int DEN_W  = hfdm_pkg::WINDOW_W + 1;
    localparam int Q_W    = (NUM_W > hfdm_pkg::FREQ_W) ? NUM_W : hfdm_pkg::FREQ_W + 1;

    logic [hfdm_pkg::WINDOW_W-1:0] r_window;
    logic [hfdm_pkg::FRAC_W-1:0]   r_low_frac;
    logic [hfdm_pkg::FRAC_W-1:0]   r_high_frac;

    logic [CNT_W-1:0]       r_count;
    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_max;
    logic                   r_dropped;
    logic [SAMPLE_BITS-1:0] r_bottom;
    logic [SAMPLE_BITS-1:0] r_top;
    logic [CNT_W-1:0]       r_rd_idx;
    logic                   r_rd_valid;
    logic                   r_high_state;
    logic [CNT_W-1:0]       r_edges;
    logic [CNT_W-1:0]       r_high;
    logic [NUM_W-1:0]       r_num_f;
    logic [NUM_W-1:0]       r_num_d;
    logic [hfdm_pkg::FREQ_W-1:0] r_freq;
    logic [hfdm_pkg::DUTY_W-1:0] r_duty;
    hfdm_pkg::t_out_item    r_out;
    logic                   r_out_valid;

    logic [SAMPLE_BITS-1:0]    n_sample;
    logic                      n_full;
    logic                      n_store;
    logic [SAMPLE_BITS-1:0]    n_span;
    logic [hfdm_pkg::FRAC_W-1:0] n_frac;
    logic [PROD_W-1:0]         n_prod;
    logic [SAMPLE_BITS-1:0]    n_thr;
    logic [SAMPLE_BITS-1:0]    n_rd_data;
    logic                      n_high_state;
    logic                      n_toggle;
    logic [NUM_W-1:0]          n_div_num;
    logic [DEN_W-1:0]          n_div_den;
    logic                      n_div_done;
    logic [NUM_W-1:0]          n_div_quot;
    logic [Q_W-1:0]            n_quot_ext;

    assign n_sample = SAMPLE_BITS'(i_sample);
    assign n_full   = r_count == CNT_W'(MAX_SAMPLES);
    assign n_store  = i_cmd.sample_we && !n_full;

    hfdm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (n_store),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (n_sample),
        .i_raddr (r_rd_idx[ADDR_W-1:0]),
        .o_rdata (n_rd_data)
    );

    assign n_span = r_max - r_min;
    assign n_frac = i_cmd.thr_hi ? r_high_frac : r_low_frac;
    assign n_prod = PROD_W'(n_span) * PROD_W'(n_frac);
    assign n_thr  = n_prod[PROD_W-1:hfdm_pkg::FRAC_W];

    always_comb begin
        n_high_state = r_high_state;
        n_toggle     = 1'b0;
        if (r_high_state && n_rd_data < r_bottom) begin
            n_high_state = 1'b0;
            n_toggle     = 1'b1;
        end else if (!r_high_state && n_rd_data > r_top) begin
            n_high_state = 1'b1;
            n_toggle     = 1'b1;
        end
    end

    assign n_div_num = i_cmd.div_sel_duty ? r_num_d : r_num_f;
    assign n_div_den = i_cmd.div_sel_duty ? DEN_W'(r_count) : {r_window, 1'b0};

    hfdm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (n_div_num),
        .i_den   (n_div_den),
        .o_done  (n_div_done),
        .o_quot  (n_div_quot)
    );

    assign n_quot_ext = Q_W'(n_div_quot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= hfdm_pkg::WINDOW_RST;
            r_low_frac  <= hfdm_pkg::LOW_RST;
            r_high_frac <= hfdm_pkg::HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_req.index)
                hfdm_pkg::CFG_WINDOW: r_window    <= i_cfg_req.wdata[hfdm_pkg::WINDOW_W-1:0];
                hfdm_pkg::CFG_LOW:    r_low_frac  <= i_cfg_req.wdata[hfdm_pkg::FRAC_W-1:0];
                hfdm_pkg::CFG_HIGH:   r_high_frac <= i_cfg_req.wdata[hfdm_pkg::FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.result_load) begin
            r_count      <= '0;
            r_min        <= '0;
            r_max        <= '0;
            r_dropped    <= 1'b0;
            r_rd_idx     <= '0;
            r_rd_valid   <= 1'b0;
            r_high_state <= 1'b0;
            r_edges      <= '0;
            r_high       <= '0;
        end else begin
            if (i_cmd.sample_we) begin
                if (n_full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                    if (r_count == '0) begin
                        r_min <= n_sample;
                        r_max <= n_sample;
                    end else if (n_sample < r_min) begin
                        r_min <= n_sample;
                    end else if (n_sample > r_max) begin
                        r_max <= n_sample;
                    end
                end
            end
            if (i_cmd.thr_lo) begin
                r_rd_idx     <= '0;
                r_high_state <= 1'b0;
                r_edges      <= '0;
                r_high       <= '0;
            end
            if (i_cmd.pass_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            r_rd_valid <= i_cmd.pass_issue;
            if (r_rd_valid) begin
                r_high_state <= n_high_state;
                if (n_toggle) begin
                    r_edges <= r_edges + 1'b1;
                end
                if (n_high_state) begin
                    r_high <= r_high + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.thr_lo) begin
            r_bottom <= n_thr;
        end
        if (i_cmd.thr_hi) begin
            r_top <= n_thr;
        end
        if (i_cmd.prep) begin
            r_num_f <= NUM_W'(r_edges) * NUM_W'(hfdm_pkg::FREQ_SCALE);
            r_num_d <= NUM_W'(r_high) * NUM_W'(hfdm_pkg::DUTY_SCALE);
        end
        if (i_cmd.take_freq) begin
            if (n_quot_ext > Q_W'(hfdm_pkg::FREQ_MAX)) begin
                r_freq <= hfdm_pkg::FREQ_MAX;
            end else begin
                r_freq <= n_quot_ext[hfdm_pkg::FREQ_W-1:0];
            end
        end
        if (i_cmd.take_duty) begin
            r_duty <= n_div_quot[hfdm_pkg::DUTY_W-1:0];
        end
        if (i_cmd.result_load) begin
            r_out.frequency_q8 <= r_freq;
            r_out.duty_q8      <= r_duty;
            r_out.overflow     <= r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.pass_done = r_rd_idx == r_count;
    assign o_status.div_done  = n_div_done;
    assign o_status.out_busy  = r_out_valid;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

endmodule

/* hw/rtl/hfdm_checker.sv */
// Port-level checker for the hysteresis frequency and duty meter, with its bind
`include "hysteresis_frequency_duty_meter_defines.svh"

module hfdm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input hfdm_pkg::t_in_item  i_in_data,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input hfdm_pkg::t_out_item i_out_data
);

    `HFDM_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "result dropped or changed while stalled")
    `HFDM_ASSERT_IMP(a_duty_range, i_out_valid, i_out_data.duty_q8 <= hfdm_pkg::DUTY_MAX, "duty above 100 percent")
    `HFDM_ASSERT_NXT(a_last_blocks, i_in_valid && i_in_ready && i_in_data.last_sample, !i_in_ready, "request taken after last sample of capture")
    `HFDM_ASSERT_IMP(a_result_after_work, $rose(i_out_valid), $past(!i_in_ready), "result shown without capture processing")

endmodule

bind hysteresis_frequency_duty_meter hfdm_checker u_hfdm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_data   (i_in.data),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

/* verif/tb_top.sv */
// Self-checking testbench of the hysteresis frequency and duty meter: captures in, results checked
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 4096;
    localparam int QUIET_LIMIT = 20000;
    localparam int TAIL_CYCLES = 120;

    logic i_clk;
    logic i_rst_n;

    hfdm_in_if  in_if();
    hfdm_out_if out_if();
    hfdm_cfg_if cfg_if();

    hysteresis_frequency_duty_meter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    logic [hfdm_pkg::WINDOW_W-1:0] window_us = hfdm_pkg::WINDOW_RST;
    logic [hfdm_pkg::FRAC_W-1:0]   low_frac  = hfdm_pkg::LOW_RST;
    logic [hfdm_pkg::FRAC_W-1:0]   high_frac = hfdm_pkg::HIGH_RST;

    logic [hfdm_pkg::SAMPLE_W-1:0] held_samples [DEPTH];
    int unsigned                   held_count      = 0;
    logic [hfdm_pkg::SAMPLE_W-1:0] level_min       = '0;
    logic [hfdm_pkg::SAMPLE_W-1:0] level_max       = '0;
    logic                          samples_dropped = 1'b0;

    hfdm_pkg::t_out_item pending_measurements[$];
    int unsigned         error_count  = 0;
    int unsigned         quiet_cycles = 0;

    bit          rx_stall_en = 1'b0;
    bit          tx_gap_en   = 1'b0;
    int unsigned burst_left  = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic hfdm_pkg::t_out_item measure_capture();
        hfdm_pkg::t_out_item m;
        logic [31:0]         span;
        logic [31:0]         bottom;
        logic [31:0]         top;
        logic                comp_high;
        longint unsigned     edges;
        longint unsigned     highs;
        longint unsigned     freq;
        longint unsigned     duty;
        span      = 32'(level_max) - 32'(level_min);
        bottom    = (span * 32'(low_frac)) >> 16;
        top       = (span * 32'(high_frac)) >> 16;
        comp_high = 1'b0;
        edges     = 0;
        highs     = 0;
        for (int unsigned k = 0; k < held_count; k++) begin
            if (comp_high && 32'(held_samples[k]) < bottom) begin
                comp_high = 1'b0;
                edges++;
            end else if (!comp_high && 32'(held_samples[k]) > top) begin
                comp_high = 1'b1;
                edges++;
            end
            if (comp_high) highs++;
        end
        if (window_us == '0) begin
            freq = 64'(hfdm_pkg::FREQ_MAX);
        end else begin
            freq = (edges * 64'd256000000) / (64'd2 * 64'(window_us));
            if (freq > 64'(hfdm_pkg::FREQ_MAX)) freq = 64'(hfdm_pkg::FREQ_MAX);
        end
        if (held_count == 0) duty = 0;
        else duty = (highs * 64'd25600) / 64'(held_count);
        m.frequency_q8 = freq[hfdm_pkg::FREQ_W-1:0];
        m.duty_q8      = duty[hfdm_pkg::DUTY_W-1:0];
        m.overflow     = samples_dropped;
        return m;
    endfunction

    function automatic void absorb_sample(hfdm_pkg::t_in_item it);
        if (held_count < DEPTH) begin
            if (held_count == 0) begin
                level_min = it.sample;
                level_max = it.sample;
            end else if (it.sample < level_min) begin
                level_min = it.sample;
            end else if (it.sample > level_max) begin
                level_max = it.sample;
            end
            held_samples[held_count] = it.sample;
            held_count++;
        end else begin
            samples_dropped = 1'b1;
        end
        if (it.last_sample) begin
            pending_measurements.push_back(measure_capture());
            held_count      = 0;
            level_min       = '0;
            level_max       = '0;
            samples_dropped = 1'b0;
        end
    endfunction

    task automatic report(string what);
        $display("%0t mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic check_result(hfdm_pkg::t_out_item got);
        hfdm_pkg::t_out_item want;
        if (pending_measurements.size() == 0) begin
            report($sformatf("unexpected result freq=%0d duty=%0d ovf=%0b",
                             got.frequency_q8, got.duty_q8, got.overflow));
        end else begin
            want = pending_measurements.pop_front();
            if (got.frequency_q8 !== want.frequency_q8)
                report($sformatf("frequency_q8 got %0d want %0d",
                                 got.frequency_q8, want.frequency_q8));
            if (got.duty_q8 !== want.duty_q8)
                report($sformatf("duty_q8 got %0d want %0d", got.duty_q8, want.duty_q8));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow got %0b want %0b", got.overflow, want.overflow));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.data.index)
                    hfdm_pkg::CFG_WINDOW: window_us = cfg_if.data.wdata;
                    hfdm_pkg::CFG_LOW:    low_frac  = cfg_if.data.wdata[hfdm_pkg::FRAC_W-1:0];
                    hfdm_pkg::CFG_HIGH:   high_frac = cfg_if.data.wdata[hfdm_pkg::FRAC_W-1:0];
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) absorb_sample(in_if.data);
            if (out_if.valid && out_if.ready) check_result(out_if.data);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        int unsigned hold;
        hold = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold == 0) begin
                if (rx_stall_en && $urandom_range(0, 2) == 0) begin
                    out_if.ready <= 1'b0;
                    hold = $urandom_range(1, 12);
                end else begin
                    out_if.ready <= 1'b1;
                    hold = $urandom_range(1, 20);
                end
            end else begin
                hold--;
            end
        end
    end

    task automatic write_reg(hfdm_pkg::t_cfg_idx idx, logic [hfdm_pkg::CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, wdata: val};
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [hfdm_pkg::WINDOW_W-1:0] win,
                                logic [hfdm_pkg::FRAC_W-1:0] lo,
                                logic [hfdm_pkg::FRAC_W-1:0] hi);
        write_reg(hfdm_pkg::CFG_WINDOW, win);
        write_reg(hfdm_pkg::CFG_LOW, {16'($urandom), lo});
        write_reg(hfdm_pkg::CFG_HIGH, {16'($urandom), hi});
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_sample(logic [hfdm_pkg::SAMPLE_W-1:0] s, logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = tx_gap_en ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_if.valid <= 1'b1;
        in_if.data  <= '{sample: s, last_sample: last};
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_measurements.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_capture(int unsigned len, bit shaped);
        int unsigned lo;
        int unsigned hi;
        int unsigned half;
        int unsigned noise;
        int          level;
        lo    = $urandom_range(0, 30000);
        hi    = $urandom_range(35000, 65535);
        half  = $urandom_range(1, 8);
        noise = $urandom_range(0, 4000);
        for (int unsigned k = 0; k < len; k++) begin
            if (shaped) begin
                level = ((k / half) % 2) ? int'(hi) : int'(lo);
                level = level + int'($urandom_range(0, 2 * noise)) - int'(noise);
                if (level < 0) level = 0;
                if (level > 65535) level = 65535;
            end else begin
                level = int'($urandom_range(0, 65535));
            end
            send_sample(hfdm_pkg::SAMPLE_W'(level), k == len - 1);
        end
    endtask

    function automatic logic [hfdm_pkg::WINDOW_W-1:0] pick_window();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return 32'($urandom_range(1, 200));
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [hfdm_pkg::FRAC_W-1:0] pick_frac();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h8000, 1'b1);
    endtask

    task automatic test_single_sample();
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b1);
    endtask

    task automatic test_register_extremes();
        drain();
        program_regs('0, '0, '1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h1234, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        drain();
        program_regs('1, '1, '0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h4000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0001, 1'b1);
        drain();
        program_regs(32'd1, '0, '0);
        for (int k = 0; k < 6; k++) send_sample((k % 2) ? 16'hFFFF : 16'h0000, k == 5);
    endtask

    task automatic test_long_captures();
        drain();
        program_regs(pick_window(), 16'd16384, 16'd49152);
        rx_stall_en = 1'b1;
        tx_gap_en   = 1'b1;
        send_capture(80, 1'b1);
        send_capture(120, 1'b1);
    endtask

    task automatic test_random_captures();
        int unsigned sent;
        int unsigned len;
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            program_regs(pick_window(), pick_frac(), pick_frac());
            rx_stall_en = (ph % 3) != 0;
            tx_gap_en   = (ph % 4) != 0;
            sent = 0;
            while (sent < 25) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                                  : $urandom_range(1, 24);
                send_capture(len, $urandom_range(0, 4) != 0);
                sent += len;
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_single_sample();
        test_register_extremes();
        test_long_captures();
        test_random_captures();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_measurements.size() != 0) report("expected results left over");
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
